[rtl/jasr_pkg.sv]
`default_nettype none

package jasr_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int POS_W     = 5;
  localparam int TIME_W    = 32;
  localparam int ALPHA_W   = 9;
  localparam int DEAD_W    = 5;
  localparam int HB_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd64;
  localparam logic [DEAD_W-1:0]  DEAD_ZONE_RESET = 5'd0;
  localparam logic [HB_W-1:0]    HEARTBEAT_RESET = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 2'd0,
    REG_DEAD_ZONE = 2'd1,
    REG_HEARTBEAT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_q8;
    logic [DEAD_W-1:0]  dead_zone;
    logic [HB_W-1:0]    heartbeat_ms;
  } cfg_t;

  // Item after the samples have been scaled down to positions 0..20.
  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              buttons_changed;
    logic [TIME_W-1:0] now_ms;
  } scaled_t;

  typedef struct packed {
    logic             publish;
    logic             x_present;
    logic             y_present;
    logic [POS_W-1:0] smooth_x;
    logic [POS_W-1:0] smooth_y;
  } result_t;

endpackage

`default_nettype wire

[rtl/jasr_prescale.sv]
`default_nettype none

module jasr_prescale (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [jasr_pkg::SAMPLE_W-1:0]    in_sample_x,
  input  wire logic [jasr_pkg::SAMPLE_W-1:0]    in_sample_y,
  input  wire logic                             in_buttons,
  input  wire logic [jasr_pkg::TIME_W-1:0]      in_now,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output jasr_pkg::scaled_t                     out_item
);

  // Division by 200 as a multiply by a rounded-up reciprocal. For samples
  // below 4096 the error stays far below the gap between multiples of 200.
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MULT_W = 13;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'((1 << DIV_SHIFT) / 200 + 1);
  localparam int PROD_W = jasr_pkg::SAMPLE_W + DIV_MULT_W;

  logic                          v1;
  logic [jasr_pkg::SAMPLE_W-1:0] sx1;
  logic [jasr_pkg::SAMPLE_W-1:0] sy1;
  logic                          btn1;
  logic [jasr_pkg::TIME_W-1:0]   now1;

  logic              adv1;
  logic              adv2;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign prod_x = PROD_W'(sx1) * PROD_W'(DIV_MULT);
  assign prod_y = PROD_W'(sy1) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sx1  <= in_sample_x;
      sy1  <= in_sample_y;
      btn1 <= in_buttons;
      now1 <= in_now;
    end
    if (adv2) begin
      out_item.pos_x           <= prod_x[DIV_SHIFT +: jasr_pkg::POS_W];
      out_item.pos_y           <= prod_y[DIV_SHIFT +: jasr_pkg::POS_W];
      out_item.buttons_changed <= btn1;
      out_item.now_ms          <= now1;
    end
  end

endmodule

`default_nettype wire

[rtl/jasr_core.sv]
`default_nettype none

module jasr_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jasr_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jasr_pkg::scaled_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jasr_pkg::result_t      out_result
);

  localparam int FILT_W = 13;
  localparam int FRAC_W = 8;
  localparam int ACC_W  = 24;
  localparam logic [jasr_pkg::ALPHA_W-1:0] Q_ONE = jasr_pkg::ALPHA_W'(1 << FRAC_W);
  localparam logic signed [ACC_W-1:0] Q_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic [FILT_W-1:0] Q_HALF_F = FILT_W'(1 << (FRAC_W - 1));
  localparam logic [jasr_pkg::POS_W-1:0] LAST_RESET = 5'd9;

  // One smoothing step, rewritten as f + a * (target - f) so that each axis
  // needs a single multiplier. The sum never goes negative.
  function automatic logic [FILT_W-1:0] smooth_step(
    input logic [FILT_W-1:0]            f,
    input logic [jasr_pkg::POS_W-1:0]   p,
    input logic [jasr_pkg::ALPHA_W-1:0] a
  );
    logic signed [FILT_W:0]                diff;
    logic signed [jasr_pkg::ALPHA_W:0]     a_s;
    logic signed [ACC_W-1:0]               prod;
    logic signed [ACC_W-1:0]               acc;
    diff = $signed({1'b0, p, FRAC_W'(0)}) - $signed({1'b0, f});
    a_s  = $signed({1'b0, a});
    prod = diff * a_s;
    acc  = $signed({(ACC_W - FILT_W - FRAC_W)'(0), f, FRAC_W'(0)}) + prod + Q_HALF;
    return acc[FRAC_W +: FILT_W];
  endfunction

  function automatic logic [jasr_pkg::POS_W-1:0] abs_diff(
    input logic [jasr_pkg::POS_W-1:0] a,
    input logic [jasr_pkg::POS_W-1:0] b
  );
    return (a > b) ? a - b : b - a;
  endfunction

  logic [FILT_W-1:0]             filter_x;
  logic [FILT_W-1:0]             filter_y;
  logic                          first_sample;
  logic [jasr_pkg::POS_W-1:0]    last_x;
  logic [jasr_pkg::POS_W-1:0]    last_y;
  logic [jasr_pkg::TIME_W-1:0]   last_heartbeat;

  logic                          fire;
  logic [jasr_pkg::ALPHA_W-1:0]  alpha_sat;
  logic [FILT_W-1:0]             filter_x_next;
  logic [FILT_W-1:0]             filter_y_next;
  logic [FILT_W-1:0]             round_x;
  logic [FILT_W-1:0]             round_y;
  logic [jasr_pkg::TIME_W-1:0]   elapsed;
  logic                          hb_due;
  logic                          change_pub;
  logic                          force_pub;
  jasr_pkg::result_t             result_next;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign alpha_sat = (cfg.alpha_q8 > Q_ONE) ? Q_ONE : cfg.alpha_q8;

  always_comb begin
    if (first_sample) begin
      filter_x_next = {in_item.pos_x, FRAC_W'(0)};
      filter_y_next = {in_item.pos_y, FRAC_W'(0)};
    end else begin
      filter_x_next = smooth_step(filter_x, in_item.pos_x, alpha_sat);
      filter_y_next = smooth_step(filter_y, in_item.pos_y, alpha_sat);
    end
  end

  assign round_x = filter_x_next + Q_HALF_F;
  assign round_y = filter_y_next + Q_HALF_F;

  assign elapsed = in_item.now_ms - last_heartbeat;
  assign hb_due  = elapsed >= {(jasr_pkg::TIME_W - jasr_pkg::HB_W)'(0), cfg.heartbeat_ms};

  always_comb begin
    result_next.smooth_x  = round_x[FRAC_W +: jasr_pkg::POS_W];
    result_next.smooth_y  = round_y[FRAC_W +: jasr_pkg::POS_W];
    result_next.x_present = abs_diff(result_next.smooth_x, last_x) > cfg.dead_zone;
    result_next.y_present = abs_diff(result_next.smooth_y, last_y) > cfg.dead_zone;
    change_pub = in_item.buttons_changed || result_next.x_present || result_next.y_present;
    force_pub  = !change_pub && hb_due;
    if (force_pub) begin
      result_next.x_present = 1'b1;
      result_next.y_present = 1'b1;
    end
    result_next.publish = change_pub || force_pub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      filter_x       <= '0;
      filter_y       <= '0;
      first_sample   <= 1'b1;
      last_x         <= LAST_RESET;
      last_y         <= LAST_RESET;
      last_heartbeat <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        filter_x     <= filter_x_next;
        filter_y     <= filter_y_next;
        first_sample <= 1'b0;
        if (result_next.publish) begin
          last_x <= result_next.smooth_x;
          last_y <= result_next.smooth_y;
        end
        if (force_pub) begin
          last_heartbeat <= in_item.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result_next;
    end
  end

  a_absent_without_publish: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.publish |-> !out_result.x_present && !out_result.y_present)
    else $error("axis marked present in a result without publish");

  a_last_tracks_publish: assert property (@(posedge clk) disable iff (rst)
    fire && result_next.publish |=>
      last_x == out_result.smooth_x && last_y == out_result.smooth_y)
    else $error("previous values did not follow the published result");

  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    fire |=> !first_sample)
    else $error("first-sample flag still set after a transfer");

  a_filter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.smooth_x <= 5'd20 && out_result.smooth_y <= 5'd20)
    else $error("smoothed position out of range");

endmodule

`default_nettype wire

[rtl/joystick_axis_smoother_reporter_top.sv]
// Each item passes the prescaler's sample and product registers, then the core's output register.
// Throughput: one item per cycle while the result side accepts; the filter
// update closes its loop in the output stage, with one multiplier per axis.
// Reset (synchronous, active high) restores the register defaults, clears the
// filters, sets the previous values to 9 and empties the pipeline at once.
`default_nettype none

module joystick_axis_smoother_reporter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_x [11:0], sample_y [23:12], now_ms [55:24]
  input  wire logic [55:0] s_axis_tdata,
  // buttons_changed
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // smooth_x [4:0], smooth_y [9:5], zero [15:10]
  output logic [15:0]      m_axis_tdata,
  // publish [0], x_present [1], y_present [2]
  output logic [2:0]       m_axis_tuser,
  input  wire logic        cfg_wen,
  input  wire logic [jasr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jasr_pkg::CFG_DATA_W-1:0] cfg_data
);

  jasr_pkg::cfg_t    cfg;
  jasr_pkg::scaled_t scaled;
  jasr_pkg::result_t result;
  logic              scaled_valid;
  logic              scaled_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_q8     <= jasr_pkg::ALPHA_RESET;
      cfg.dead_zone    <= jasr_pkg::DEAD_ZONE_RESET;
      cfg.heartbeat_ms <= jasr_pkg::HEARTBEAT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        jasr_pkg::REG_ALPHA: begin
          cfg.alpha_q8 <= cfg_data[jasr_pkg::ALPHA_W-1:0];
        end
        jasr_pkg::REG_DEAD_ZONE: begin
          cfg.dead_zone <= cfg_data[jasr_pkg::DEAD_W-1:0];
        end
        jasr_pkg::REG_HEARTBEAT: begin
          cfg.heartbeat_ms <= cfg_data[jasr_pkg::HB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  jasr_prescale u_prescale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample_x (s_axis_tdata[11:0]),
    .in_sample_y (s_axis_tdata[23:12]),
    .in_buttons  (s_axis_tuser),
    .in_now      (s_axis_tdata[55:24]),
    .out_valid   (scaled_valid),
    .out_ready   (scaled_ready),
    .out_item    (scaled)
  );

  jasr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (scaled_valid),
    .in_ready   (scaled_ready),
    .in_item    (scaled),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {6'd0, result.smooth_y, result.smooth_x};
  assign m_axis_tuser = {result.y_present, result.x_present, result.publish};

endmodule

`default_nettype wire

[sim/jasr_report_checker.sv]
`timescale 1ns / 100ps

// Watches the sample stream, the result stream and the register port of the
// smoother. It predicts the report for every sample transfer and compares it
// with the result transfers in order.
module jasr_report_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  input  wire logic                                s_axis_tready,
  input  wire logic [55:0]                         s_axis_tdata,
  input  wire logic                                s_axis_tuser,
  input  wire logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic [15:0]                         m_axis_tdata,
  input  wire logic [2:0]                          m_axis_tuser,
  input  wire logic                                cfg_wen,
  input  wire logic [jasr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [jasr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                       mismatch_count,
  output int                                       reports_pending
);

  localparam int unsigned POS_DIVISOR = 200;
  localparam int unsigned Q8_ONE      = 256;
  localparam int unsigned Q8_HALF     = 128;
  localparam logic [jasr_pkg::POS_W-1:0] PREV_RESET = 5'd9;

  logic [jasr_pkg::ALPHA_W-1:0] alpha_q8;
  logic [jasr_pkg::DEAD_W-1:0]  dead_zone;
  logic [jasr_pkg::HB_W-1:0]    heartbeat_ms;

  logic [12:0]                 level_x;
  logic [12:0]                 level_y;
  logic                        awaiting_first;
  logic [jasr_pkg::POS_W-1:0]  prev_x;
  logic [jasr_pkg::POS_W-1:0]  prev_y;
  logic [jasr_pkg::TIME_W-1:0] heartbeat_stamp;

  jasr_pkg::result_t expected_reports[$];

  function automatic logic [12:0] ema_step(input logic [12:0] level,
                                           input logic [jasr_pkg::SAMPLE_W-1:0] sample,
                                           input int unsigned weight);
    int unsigned pos;
    int unsigned acc;
    pos = sample / POS_DIVISOR;
    acc = level * (Q8_ONE - weight) + (pos << 8) * weight + Q8_HALF;
    return acc[20:8];
  endfunction

  task automatic predict_report(input logic [jasr_pkg::SAMPLE_W-1:0] sx,
                                input logic [jasr_pkg::SAMPLE_W-1:0] sy,
                                input logic btn,
                                input logic [jasr_pkg::TIME_W-1:0] now,
                                output jasr_pkg::result_t rep);
    int unsigned weight;
    int unsigned rx;
    int unsigned ry;
    int unsigned dx;
    int unsigned dy;
    logic xp;
    logic yp;
    logic pub;
    weight = (alpha_q8 > Q8_ONE) ? Q8_ONE : alpha_q8;
    if (awaiting_first) begin
      level_x = 13'((sx / POS_DIVISOR) << 8);
      level_y = 13'((sy / POS_DIVISOR) << 8);
      awaiting_first = 1'b0;
    end else begin
      level_x = ema_step(level_x, sx, weight);
      level_y = ema_step(level_y, sy, weight);
    end
    rx = (int'(level_x) + Q8_HALF) >> 8;
    ry = (int'(level_y) + Q8_HALF) >> 8;
    dx = (rx > prev_x) ? rx - prev_x : prev_x - rx;
    dy = (ry > prev_y) ? ry - prev_y : prev_y - ry;
    xp = dx > dead_zone;
    yp = dy > dead_zone;
    pub = btn || xp || yp;
    // The elapsed time wraps with the 32-bit timestamp.
    if (!pub && jasr_pkg::TIME_W'(now - heartbeat_stamp) >= heartbeat_ms) begin
      xp = 1'b1;
      yp = 1'b1;
      pub = 1'b1;
      heartbeat_stamp = now;
    end
    if (pub) begin
      prev_x = rx[jasr_pkg::POS_W-1:0];
      prev_y = ry[jasr_pkg::POS_W-1:0];
    end
    rep.publish   = pub;
    rep.x_present = xp;
    rep.y_present = yp;
    rep.smooth_x  = rx[jasr_pkg::POS_W-1:0];
    rep.smooth_y  = ry[jasr_pkg::POS_W-1:0];
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    jasr_pkg::result_t rep;
    jasr_pkg::result_t want;
    if (rst) begin
      alpha_q8        = jasr_pkg::ALPHA_RESET;
      dead_zone       = jasr_pkg::DEAD_ZONE_RESET;
      heartbeat_ms    = jasr_pkg::HEARTBEAT_RESET;
      level_x         = '0;
      level_y         = '0;
      awaiting_first  = 1'b1;
      prev_x          = PREV_RESET;
      prev_y          = PREV_RESET;
      heartbeat_stamp = '0;
      mismatch_count  = 0;
      expected_reports.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          jasr_pkg::REG_ALPHA:     alpha_q8     = cfg_data[jasr_pkg::ALPHA_W-1:0];
          jasr_pkg::REG_DEAD_ZONE: dead_zone    = cfg_data[jasr_pkg::DEAD_W-1:0];
          jasr_pkg::REG_HEARTBEAT: heartbeat_ms = cfg_data[jasr_pkg::HB_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_report(s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tuser,
                       s_axis_tdata[55:24], rep);
        expected_reports.push_back(rep);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer arrived with no report expected");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("publish", want.publish, m_axis_tuser[0]);
          compare_field("x_present", want.x_present, m_axis_tuser[1]);
          compare_field("y_present", want.y_present, m_axis_tuser[2]);
          compare_field("smooth_x", want.smooth_x, m_axis_tdata[4:0]);
          compare_field("smooth_y", want.smooth_y, m_axis_tdata[9:5]);
        end
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES         = 400000;
  localparam int HOLD_OFF_CYCLES      = 200;
  localparam int SETTLE_CYCLES        = 6;
  localparam int READINGS_PER_SETTING = 144;
  localparam int SETTING_COUNT        = 8;
  // Index past the last register; writes to it must change nothing.
  localparam logic [jasr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [55:0]                     s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [15:0]                     m_axis_tdata;
  logic [2:0]                      m_axis_tuser;
  logic                            cfg_wen;
  logic [jasr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jasr_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int reports_pending;
  int cycle_count;

  int idle_pct;
  int stall_pct;
  bit hold_req;

  logic [jasr_pkg::SAMPLE_W-1:0] aim_x;
  logic [jasr_pkg::SAMPLE_W-1:0] aim_y;
  logic [jasr_pkg::TIME_W-1:0]   clock_ms;

  joystick_axis_smoother_reporter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  jasr_report_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("joystick_axis_smoother_reporter_top test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request so that the
  // block backs up into its input.
  initial begin
    int hold_count;
    hold_count = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_count = HOLD_OFF_CYCLES;
      end
      if (hold_count > 0) begin
        m_axis_tready = 1'b0;
        hold_count--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Called and returning at a falling edge.
  task automatic send_reading(input logic [jasr_pkg::SAMPLE_W-1:0] sx,
                              input logic [jasr_pkg::SAMPLE_W-1:0] sy,
                              input logic btn,
                              input logic [jasr_pkg::TIME_W-1:0] now);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 56'({$urandom, $urandom});
      s_axis_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {now, sy, sx};
    s_axis_tuser  = btn;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [jasr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jasr_pkg::CFG_DATA_W-1:0] value);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Upper data bits beyond each register's width are filled at random; the
  // block must drop them.
  task automatic apply_setting(input int setting);
    logic [jasr_pkg::ALPHA_W-1:0] alpha;
    logic [jasr_pkg::DEAD_W-1:0]  dz;
    logic [jasr_pkg::HB_W-1:0]    hb;
    case (setting)
      0: begin alpha = 9'd256; dz = 5'd0;  hb = 16'd1;     end
      1: begin alpha = 9'd0;   dz = 5'd20; hb = 16'd65535; end
      2: begin alpha = 9'd511; dz = 5'd31; hb = 16'd0;     end
      3: begin alpha = 9'd1;   dz = 5'd1;  hb = 16'd200;   end
      4: begin alpha = 9'd128; dz = 5'd2;  hb = 16'd50;    end
      5: begin alpha = 9'd257; dz = 5'd5;  hb = 16'd1000;  end
      6: begin
        alpha = 9'($urandom);
        dz    = 5'($urandom);
        hb    = 16'($urandom_range(1, 3000));
      end
      default: begin alpha = 9'd32; dz = 5'd0; hb = 16'd65535; end
    endcase
    write_reg(jasr_pkg::REG_ALPHA, {7'($urandom), alpha});
    write_reg(jasr_pkg::REG_DEAD_ZONE, {11'($urandom), dz});
    write_reg(jasr_pkg::REG_HEARTBEAT, hb);
    write_reg(REG_SPARE, 16'($urandom));
  endtask

  function automatic logic [jasr_pkg::SAMPLE_W-1:0] jitter(
    input logic [jasr_pkg::SAMPLE_W-1:0] center
  );
    int v;
    v = int'(center) + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[jasr_pkg::SAMPLE_W-1:0];
  endfunction

  // Mostly a stick held near a target that moves only by rare jumps, with small noise, so that
  // the dead zone and the heartbeat both matter, with some jumps and noise.
  task automatic send_random_reading();
    int sel;
    int tick;
    logic [jasr_pkg::SAMPLE_W-1:0] sx;
    logic [jasr_pkg::SAMPLE_W-1:0] sy;
    logic btn;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      aim_x = 12'($urandom);
      aim_y = 12'($urandom);
    end
    sx = jitter(aim_x);
    sy = jitter(aim_y);
    if (sel >= 84 && sel < 90) begin
      sx = sel[0] ? '1 : '0;
      sy = sel[1] ? '1 : '0;
    end else if (sel >= 90) begin
      sx = 12'($urandom);
      if (sel >= 95) sy = 12'($urandom);
    end
    btn = ($urandom_range(0, 99) < 10);
    tick = $urandom_range(0, 99);
    if (tick < 55) clock_ms += $urandom_range(0, 40);
    else if (tick < 88) clock_ms += $urandom_range(0, 1200);
    else if (tick < 98) clock_ms += $urandom_range(0, 70000);
    else clock_ms = $urandom;
    send_reading(sx, sy, btn, clock_ms);
  endtask

  initial begin
    int setting;
    int n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_wen       = 1'b0;
    cfg_index     = jasr_pkg::REG_ALPHA;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    aim_x         = 12'd2048;
    aim_y         = 12'd2048;
    clock_ms      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default registers: the first sample loads the filter, then the
    // boundaries of the division by 200 on both axes.
    send_reading(12'd4095, 12'd0, 1'b0, 32'd0);
    send_reading(12'd4000, 12'd199, 1'b0, 32'd10);
    send_reading(12'd3999, 12'd200, 1'b0, 32'd20);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd30);
    wait_idle();

    // Full weight on the new sample makes the positions exact, so the
    // button-only report and the heartbeat timing can be hit directly.
    write_reg(jasr_pkg::REG_ALPHA, 16'd256);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd40);
    send_reading(12'd1800, 12'd1800, 1'b1, 32'd50);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd60);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd500);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd999);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'd1000);
    send_reading(12'd1800, 12'd1800, 1'b0, 32'hFFFF_FFF0);
    // Exactly one interval later across the timestamp wrap.
    send_reading(12'd1800, 12'd1800, 1'b0, 32'h0000_01E4);
    send_reading(12'd0, 12'd4095, 1'b1, 32'h0000_01E5);
    send_reading(12'd4095, 12'd0, 1'b0, 32'hFFFF_FFFF);
    clock_ms = 32'h0000_0200;
    wait_idle();

    for (setting = 0; setting < SETTING_COUNT; setting++) begin
      case (setting / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      apply_setting(setting);
      if (setting == 3) clock_ms = 32'hFFFF_FC00;
      if (setting == 0) hold_req = 1'b1;
      for (n = 0; n < READINGS_PER_SETTING; n++) send_random_reading();
      wait_idle();
    end

    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("joystick_axis_smoother_reporter_top test passed");
    end else begin
      $display("joystick_axis_smoother_reporter_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/jasr_pkg.sv
rtl/jasr_prescale.sv
rtl/jasr_core.sv
rtl/joystick_axis_smoother_reporter_top.sv
sim/jasr_report_checker.sv
sim/testbench.sv
